// ----- rtl/time_window_vector_average_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the time window vector average block
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_VECTOR_AVERAGE_TOP_ASSERT_SVH
`define TIME_WINDOW_VECTOR_AVERAGE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define TWVA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define TWVA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define TWVA_ASSERT(label, clk, rst_n, prop, msg)
`define TWVA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- rtl/twva_pkg.sv -----
// ----------------------------------------------------------------------------
// Time window vector average package
// Shared constants, transaction types and sequencer states.
// ----------------------------------------------------------------------------
package twva_pkg;

    localparam int unsigned RING_DEPTH_DEFAULT = 32;
    localparam int unsigned COORD_W            = 32;
    localparam int unsigned STAMP_W            = 32;
    localparam int unsigned KEPT_W             = 6;
    localparam logic [31:0] WINDOW_RESET       = 32'd1000;

    typedef struct packed {
        logic [31:0]        now_time;
        logic               sample_present;
        logic [31:0]        sample_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] avg_x;
        logic signed [31:0] avg_y;
        logic signed [31:0] avg_z;
        logic [31:0]        latest_stamp;
        logic [5:0]         kept_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT_RD,
        S_EVICT_CHK,
        S_APPEND,
        S_DIV_START,
        S_DIV_RUN,
        S_DELIVER
    } t_state;

endpackage

// ----- rtl/twva_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module twva_ram #(
    parameter int unsigned WIDTH = twva_pkg::COORD_W,
    parameter int unsigned DEPTH = twva_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/twva_div.sv -----
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module twva_div #(
    parameter int unsigned DIVIDEND_W = twva_pkg::COORD_W + 5,
    parameter int unsigned DIVISOR_W  = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIVIDEND_W-1:0]        i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic                         o_done,
    output logic [twva_pkg::COORD_W-1:0] o_quotient
);

    localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);
    localparam int unsigned Q_W    = twva_pkg::COORD_W;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic                  r_neg;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quot;

    logic [DIVIDEND_W-1:0] w_mag;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // The dividend is divided as a magnitude; the sign is put back at the end.
    assign w_mag   = i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_trial = {r_rem, r_quot[DIVIDEND_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg     <= i_dividend[DIVIDEND_W-1];
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quot    <= w_mag;
        end else if (r_busy) begin
            r_rem  <= w_fits ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quot[Q_W-1:0] + 1'b1) : r_quot[Q_W-1:0];

endmodule

// ----- rtl/time_window_vector_average_top.sv -----
// ----------------------------------------------------------------------------
// Time window vector average, top level
// Keeps a ring of timestamped 3-D positions, drops those older than the
// window and reports the per-axis mean of what remains.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------
//  input     in         i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_ready o_out_item (t_out_item)
//  config    in         i_cfg_we (no wait)        i_cfg_wdata (window length)
//
//  An accepted input transaction passes through the eviction read and check
//  states for every evicted sample and once more for the first kept one, then
//  the append state (entered again when a full ring first drops its oldest
//  entry), the divide start, divide run and deliver states. DIVIDEND_W is
//  32 + log2(RING_DEPTH) (37 at the default depth). A step that leaves the
//  ring empty produces no result and ends in the divide start state.
//  Eviction is bounded by the registered read of the sample memories;
//  the three axis divisions run side by side, one quotient bit per cycle.
//  Reset is synchronous and active low; the memories need no clearing.
//  A finished result waits in the output register while the next input
//  transaction is taken; only the final load waits on a stalled output.
//
`include "time_window_vector_average_top_assert.svh"

module time_window_vector_average_top #(
    parameter int unsigned RING_DEPTH = twva_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  twva_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output twva_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    localparam int unsigned COORD_W = twva_pkg::COORD_W;
    localparam int unsigned KEPT_W  = twva_pkg::KEPT_W;
    localparam int unsigned IDX_W   = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int unsigned SUM_W   = COORD_W + IDX_W;
    localparam int unsigned POS_W   = 3 * COORD_W;
    localparam int unsigned EXT_W   = SUM_W - COORD_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_WIDE = (CNT_W + 1)'(RING_DEPTH);

    // Sequencer and ring state.
    twva_pkg::t_state    r_state, n_state;
    logic [31:0]         r_window;
    twva_pkg::t_in_item  r_item, n_item;
    logic [IDX_W-1:0]    r_oldest, n_oldest;
    logic [CNT_W-1:0]    r_count, n_count;
    logic signed [SUM_W-1:0] r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y, n_sum_y;
    logic signed [SUM_W-1:0] r_sum_z, n_sum_z;
    logic [31:0]         r_latest, n_latest;
    twva_pkg::t_out_item r_out_item, n_out_item;
    logic                r_out_valid, n_out_valid;

    // Memory and datapath signals.
    logic [31:0]             w_stamp_rd;
    logic [POS_W-1:0]        w_pos_rd;
    logic [POS_W-1:0]        w_pos_wr;
    logic                    w_we;
    logic [CNT_W:0]          w_slot_wide;
    logic [IDX_W-1:0]        w_slot;
    logic [IDX_W-1:0]        w_oldest_inc;
    logic                    w_stale;
    logic signed [SUM_W-1:0] w_old_x, w_old_y, w_old_z;
    logic signed [SUM_W-1:0] w_new_x, w_new_y, w_new_z;
    logic                    w_div_start;
    logic [2:0]              w_div_done;
    logic [COORD_W-1:0]      w_quot_x, w_quot_y, w_quot_z;

    // The read port always points at the oldest entry. The oldest index moves
    // in the check state before a fresh read, and in a full-ring drop before
    // an append that uses no read data, so the data used is that entry's.
    // Writes happen only in append, long before the slot is read again.
    twva_ram #(
        .WIDTH (twva_pkg::STAMP_W),
        .DEPTH (RING_DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (r_item.sample_time),
        .i_raddr (r_oldest),
        .o_rdata (w_stamp_rd)
    );

    twva_ram #(
        .WIDTH (POS_W),
        .DEPTH (RING_DEPTH)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_pos_wr),
        .i_raddr (r_oldest),
        .o_rdata (w_pos_rd)
    );

    assign w_pos_wr = {r_item.pos_x, r_item.pos_y, r_item.pos_z};

    // The new sample goes right behind the newest one in the ring.
    assign w_slot_wide = (CNT_W + 1)'(r_oldest) + (CNT_W + 1)'(r_count);
    assign w_slot      = (w_slot_wide >= DEPTH_WIDE) ? IDX_W'(w_slot_wide - DEPTH_WIDE)
                                                     : IDX_W'(w_slot_wide);
    assign w_oldest_inc = (r_oldest == LAST_IDX) ? '0 : r_oldest + 1'b1;

    // A sample is stale when its stamp plus the window lies before now. The
    // sum is one bit wider, so a window reaching before time zero never wraps.
    assign w_stale = ({1'b0, w_stamp_rd} + {1'b0, r_window}) < {1'b0, r_item.now_time};

    assign w_old_x = {{EXT_W{w_pos_rd[POS_W-1]}}, w_pos_rd[POS_W-1 -: COORD_W]};
    assign w_old_y = {{EXT_W{w_pos_rd[2*COORD_W-1]}}, w_pos_rd[2*COORD_W-1 -: COORD_W]};
    assign w_old_z = {{EXT_W{w_pos_rd[COORD_W-1]}}, w_pos_rd[COORD_W-1:0]};
    assign w_new_x = {{EXT_W{r_item.pos_x[COORD_W-1]}}, r_item.pos_x};
    assign w_new_y = {{EXT_W{r_item.pos_y[COORD_W-1]}}, r_item.pos_y};
    assign w_new_z = {{EXT_W{r_item.pos_z[COORD_W-1]}}, r_item.pos_z};

    // One serial divider per axis; all three start together and finish in
    // the same cycle.
    twva_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_x),
        .i_divisor  (r_count),
        .o_done     (w_div_done[0]),
        .o_quotient (w_quot_x)
    );

    twva_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_y),
        .i_divisor  (r_count),
        .o_done     (w_div_done[1]),
        .o_quotient (w_quot_y)
    );

    twva_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum_z),
        .i_divisor  (r_count),
        .o_done     (w_div_done[2]),
        .o_quotient (w_quot_z)
    );

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_z     = r_sum_z;
        n_latest    = r_latest;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_div_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            twva_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = twva_pkg::S_EVICT_RD;
                end
            end
            twva_pkg::S_EVICT_RD: begin
                // The oldest entry is being read; an empty ring stops eviction.
                if (r_count == '0) begin
                    n_state = twva_pkg::S_APPEND;
                end else begin
                    n_state = twva_pkg::S_EVICT_CHK;
                end
            end
            twva_pkg::S_EVICT_CHK: begin
                if (w_stale) begin
                    n_sum_x  = r_sum_x - w_old_x;
                    n_sum_y  = r_sum_y - w_old_y;
                    n_sum_z  = r_sum_z - w_old_z;
                    n_oldest = w_oldest_inc;
                    n_count  = r_count - 1'b1;
                    n_state  = twva_pkg::S_EVICT_RD;
                end else begin
                    n_state = twva_pkg::S_APPEND;
                end
            end
            twva_pkg::S_APPEND: begin
                if (!r_item.sample_present) begin
                    n_state = twva_pkg::S_DIV_START;
                end else if (r_count == FULL_COUNT) begin
                    // A full ring drops its oldest entry first and appends in
                    // the following cycle.
                    n_sum_x  = r_sum_x - w_old_x;
                    n_sum_y  = r_sum_y - w_old_y;
                    n_sum_z  = r_sum_z - w_old_z;
                    n_oldest = w_oldest_inc;
                    n_count  = r_count - 1'b1;
                end else begin
                    w_we     = 1'b1;
                    n_sum_x  = r_sum_x + w_new_x;
                    n_sum_y  = r_sum_y + w_new_y;
                    n_sum_z  = r_sum_z + w_new_z;
                    n_count  = r_count + 1'b1;
                    n_latest = r_item.sample_time;
                    n_state  = twva_pkg::S_DIV_START;
                end
            end
            twva_pkg::S_DIV_START: begin
                if (r_count == '0) begin
                    n_state = twva_pkg::S_IDLE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = twva_pkg::S_DIV_RUN;
                end
            end
            twva_pkg::S_DIV_RUN: begin
                if (&w_div_done) begin
                    n_state = twva_pkg::S_DELIVER;
                end
            end
            twva_pkg::S_DELIVER: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_item.avg_x        = w_quot_x;
                    n_out_item.avg_y        = w_quot_y;
                    n_out_item.avg_z        = w_quot_z;
                    n_out_item.latest_stamp = r_latest;
                    n_out_item.kept_count   = KEPT_W'(r_count);
                    n_out_valid             = 1'b1;
                    n_state                 = twva_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = twva_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twva_pkg::S_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_z     <= n_sum_z;
            r_out_valid <= n_out_valid;
        end
    end

    // The user must write the window register only when idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= twva_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_latest   <= n_latest;
        r_out_item <= n_out_item;
    end

    assign o_in_ready  = (r_state == twva_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `TWVA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT, "entry count above ring depth")
    `TWVA_ASSERT(a_evict_nonempty, i_clk, i_rst_n, (r_state == twva_pkg::S_EVICT_CHK) |-> (r_count != '0), "eviction check on an empty ring")
    `TWVA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken again before the transaction was processed")

endmodule

// ----- sim/window_average_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window average checker
// Watches the step, result and window-register ports of the block, keeps its
// own sample ring and running sums, and compares every result transaction
// against the oldest predicted average.
// ----------------------------------------------------------------------------
module window_average_checker #(
    parameter int unsigned RING_DEPTH = twva_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  twva_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  twva_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_results_owed
);

    logic [31:0]         window_len;
    logic [31:0]         stamp_ring [RING_DEPTH];
    logic signed [31:0]  x_ring [RING_DEPTH];
    logic signed [31:0]  y_ring [RING_DEPTH];
    logic signed [31:0]  z_ring [RING_DEPTH];
    int unsigned         oldest_slot;
    int unsigned         kept;
    longint              sum_x;
    longint              sum_y;
    longint              sum_z;
    twva_pkg::t_out_item expected_avgs [$];
    int                  fails;
    int                  result_no;

    function automatic void drop_oldest_sample();
        sum_x -= x_ring[oldest_slot];
        sum_y -= y_ring[oldest_slot];
        sum_z -= z_ring[oldest_slot];
        oldest_slot = (oldest_slot + 1) % RING_DEPTH;
        kept--;
    endfunction

    function automatic void flag_failure(input string what);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] result %0d: %s", $time, result_no, what);
        end
    endfunction

    always @(posedge i_clk) begin : track
        twva_pkg::t_out_item want;
        twva_pkg::t_out_item got;
        longint              n;
        longint              quot;
        int unsigned         slot;
        string               bad;

        if (!i_rst_n) begin
            window_len  = twva_pkg::WINDOW_RESET;
            oldest_slot = 0;
            kept        = 0;
            sum_x       = 0;
            sum_y       = 0;
            sum_z       = 0;
            fails       = 0;
            result_no   = 0;
            expected_avgs.delete();
        end else begin
            if (i_cfg_we) begin
                window_len = i_cfg_wdata;
            end

            // Results are checked before a step accepted at the same edge is
            // predicted, so the oldest expectation is always the one compared.
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                result_no++;
                if (expected_avgs.size() == 0) begin
                    flag_failure($sformatf("unexpected result x=%h y=%h z=%h stamp=%h count=%0d",
                                           got.avg_x, got.avg_y, got.avg_z,
                                           got.latest_stamp, got.kept_count));
                end else begin
                    want = expected_avgs[0];
                    expected_avgs.delete(0);
                    bad  = "";
                    if (got.avg_x !== want.avg_x) bad = {bad, " avg_x"};
                    if (got.avg_y !== want.avg_y) bad = {bad, " avg_y"};
                    if (got.avg_z !== want.avg_z) bad = {bad, " avg_z"};
                    if (got.latest_stamp !== want.latest_stamp) bad = {bad, " latest_stamp"};
                    if (got.kept_count !== want.kept_count) bad = {bad, " kept_count"};
                    if (bad != "") begin
                        flag_failure($sformatf(
                            "wrong%s: expected %h %h %h %h %0d, got %h %h %h %h %0d", bad,
                            want.avg_x, want.avg_y, want.avg_z, want.latest_stamp,
                            want.kept_count, got.avg_x, got.avg_y, got.avg_z,
                            got.latest_stamp, got.kept_count));
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                // The age test is done in 64 bits so a window reaching past
                // time zero never wraps around.
                while (kept > 0 && ({32'd0, stamp_ring[oldest_slot]} + {32'd0, window_len})
                                   < {32'd0, i_in_item.now_time}) begin
                    drop_oldest_sample();
                end
                if (i_in_item.sample_present) begin
                    if (kept >= RING_DEPTH) begin
                        drop_oldest_sample();
                    end
                    slot             = (oldest_slot + kept) % RING_DEPTH;
                    stamp_ring[slot] = i_in_item.sample_time;
                    x_ring[slot]     = i_in_item.pos_x;
                    y_ring[slot]     = i_in_item.pos_y;
                    z_ring[slot]     = i_in_item.pos_z;
                    sum_x           += x_ring[slot];
                    sum_y           += y_ring[slot];
                    sum_z           += z_ring[slot];
                    kept++;
                end
                if (kept != 0) begin
                    n                 = kept;
                    slot              = (oldest_slot + kept - 1) % RING_DEPTH;
                    quot              = sum_x / n;
                    want.avg_x        = quot[31:0];
                    quot              = sum_y / n;
                    want.avg_y        = quot[31:0];
                    quot              = sum_z / n;
                    want.avg_z        = quot[31:0];
                    want.latest_stamp = stamp_ring[slot];
                    want.kept_count   = kept[5:0];
                    expected_avgs.insert(expected_avgs.size(), want);
                end
            end
        end

        o_fail_count   <= fails;
        o_results_owed <= expected_avgs.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time window vector average testbench
// Drives publish steps and window-register writes into the block, stalls both
// channels at random and leaves all result checking to the checker module.
// ----------------------------------------------------------------------------
module tb_top;

    // Longer than the longest transaction (full eviction or a drop, then the
    // divide), so this many quiet cycles guarantee the block has gone idle.
    localparam int unsigned SETTLE_CYCLES = 128;
    // Cycles without any accepted transaction before the run is abandoned.
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned GAP_MAX       = 19;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    twva_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    twva_pkg::t_out_item o_out_item;
    logic                i_cfg_we    = 1'b0;
    logic [31:0]         i_cfg_wdata = '0;

    int          fail_count;
    int          results_owed;

    // When set, both sides run flat out with no idle cycles at all.
    logic        no_idle     = 1'b0;
    logic [31:0] now_ticks   = '0;
    int          windows_used;
    int          steps_taken;
    int          averages_taken;
    int unsigned quiet_cycles;

    int unsigned out_hold;
    logic        out_hold_drawn;

    always #5 i_clk = ~i_clk;

    time_window_vector_average_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    window_average_checker u_avg_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_item     (o_out_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    // Each side draws a fresh wait for every transaction.
    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Mostly full-range coordinates, with small values and the extremes mixed
    // in so the sums hit both the sign boundary and the 37-bit limits.
    function automatic logic [31:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $urandom;
        if (roll < 8) return $urandom_range(0, 2000) - 1000;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic twva_pkg::t_in_item make_step(input logic [31:0] now,
                                                     input logic present,
                                                     input logic [31:0] stamp,
                                                     input logic [31:0] x,
                                                     input logic [31:0] y,
                                                     input logic [31:0] z);
        twva_pkg::t_in_item it;
        it.now_time       = now;
        it.sample_present = present;
        it.sample_time    = stamp;
        it.pos_x          = x;
        it.pos_y          = y;
        it.pos_z          = z;
        return it;
    endfunction

    // Presents one publish step and returns at the edge where it is taken.
    // Valid is only dropped when an idle gap follows, so back-to-back
    // transactions keep it high across the edge.
    task automatic send_step(input twva_pkg::t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The window register is only written with the block idle: every owed
    // result has come out and a step that produced none has had time to end.
    task automatic write_window(input logic [31:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        windows_used++;
    endtask

    // One random phase: time walks forward by up to 'stride' ticks per step,
    // with rare jumps anywhere. Most new samples are stamped close to the
    // current time; some are stale, some fully random, a few in the future.
    task automatic run_phase(input logic [31:0] window, input int unsigned steps,
                             input int unsigned stride);
        twva_pkg::t_in_item it;
        int unsigned        roll;
        write_window(window);
        no_idle <= ($urandom_range(0, 3) == 0);
        repeat (steps) begin
            if ($urandom_range(0, 99) < 2) now_ticks = $urandom;
            else now_ticks += $urandom_range(0, stride);
            it.now_time       = now_ticks;
            it.sample_present = ($urandom_range(0, 99) < 85);
            roll = $urandom_range(0, 99);
            if (roll < 70)      it.sample_time = now_ticks - $urandom_range(0, 20);
            else if (roll < 85) it.sample_time = now_ticks - $urandom_range(0, 3000);
            else if (roll < 95) it.sample_time = $urandom;
            else                it.sample_time = now_ticks + $urandom_range(1, 50);
            it.pos_x = pick_coord();
            it.pos_y = pick_coord();
            it.pos_z = pick_coord();
            send_step(it);
        end
    endtask

    // Result side: after a result shows up, wait a drawn number of cycles
    // before taking it. After each accepted transaction ready is sometimes
    // left high so the next result can be taken the moment it appears.
    always @(posedge i_clk) begin : result_sink
        int unsigned n;
        if (!i_rst_n) begin
            i_out_ready    <= 1'b0;
            out_hold       <= 0;
            out_hold_drawn <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            out_hold_drawn <= 1'b0;
            i_out_ready    <= no_idle || ($urandom_range(0, 3) == 0);
        end else if (o_out_valid) begin
            if (!out_hold_drawn) begin
                n              = pick_gap();
                out_hold_drawn <= 1'b1;
                out_hold       <= n;
                i_out_ready    <= (n == 0);
            end else if (out_hold > 1) begin
                out_hold <= out_hold - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a correct block never goes this long without moving a
    // transaction on either channel, even across the idle pauses.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles   <= 0;
            steps_taken    <= 0;
            averages_taken <= 0;
        end else begin
            if (i_in_valid && o_in_ready) steps_taken <= steps_taken + 1;
            if (o_out_valid && i_out_ready) averages_taken <= averages_taken + 1;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        windows_used = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed steps under the reset window of 1000 ticks.
        // Empty store and no sample: nothing comes out.
        send_step(make_step(32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_step(make_step(32'd0, 1'b1, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // Mean of the two extremes is -0.5, which truncates to zero.
        send_step(make_step(32'd5, 1'b1, 32'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_step(make_step(32'd10, 1'b1, 32'd10, -32'sd3, 32'sd3, -32'sd1));
        // Window longer than the current time: the age limit lies before zero.
        send_step(make_step(32'd500, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        // Stamps 0 and 5 age out; the new sample is already stale but still kept.
        send_step(make_step(32'd1006, 1'b1, 32'd3, 32'sd1, 32'sd2, 32'sd3));
        // Both remaining samples age out and eviction stops on the empty store.
        send_step(make_step(32'd1012, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        // Out-of-order stamps: 1500 sits behind 2000 and survives until it is
        // the oldest entry.
        send_step(make_step(32'd2000, 1'b1, 32'd2000, 32'h0001_0000, 32'hFFFF_0000,
                            32'h7FFF_FFFF));
        send_step(make_step(32'd2001, 1'b1, 32'd1500, 32'h8000_0000, 32'h0000_8000,
                            32'hFFFF_FFFF));
        send_step(make_step(32'd2600, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_step(make_step(32'd3001, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        // Extremes of time: all-ones stamps, then a time-zero stamp that is
        // stale on arrival, then time wrapping back to small values.
        send_step(make_step(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'd0));
        send_step(make_step(32'hFFFF_FFFF, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
        send_step(make_step(32'd1500, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_step(make_step(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));

        // Random phases. The widest window with a slow clock keeps every
        // sample, so the ring fills and drops its oldest entry.
        now_ticks = 32'd4000;
        run_phase(32'hFFFF_FFFF, 92, 3);
        run_phase(32'd1, 92, 2);
        run_phase(32'd1000, 92, 60);
        now_ticks = 32'hFFFF_F000;
        run_phase(32'd5000, 92, 200);
        run_phase(32'd50, 92, 10);
        run_phase(32'd20000, 92, 400);
        run_phase(32'd300, 92, 40);
        run_phase(32'hFFFF_FFFF, 92, 1000);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d publish steps and checked %0d averages under %0d window settings,",
                 steps_taken, averages_taken, windows_used + 1);
        $display("from a one-tick window to the full 32-bit window, with full-ring drops.");
        if (fail_count == 0 && results_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- time_window_vector_average_top.f -----
+incdir+rtl
rtl/twva_pkg.sv
rtl/twva_ram.sv
rtl/twva_div.sv
rtl/time_window_vector_average_top.sv
sim/window_average_checker.sv
sim/tb_top.sv
